FILE: rtl/core/i8mm_pkg.sv
// ----------------------------------------------------------------------------
// i8mm_pkg
// Shared types, codes and helpers for the int8 zero-point matrix multiply.
// ----------------------------------------------------------------------------
package i8mm_pkg;

  // store geometry
  localparam int MAX_DIM  = 8;
  localparam int DIM_W    = 4;                        // dimension register width
  localparam int POS_W    = $clog2(MAX_DIM);          // row / column / depth index
  localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;

  // payload widths
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 6;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 32;

  // arithmetic widths
  localparam int VAL_W  = BYTE_W + 1;                 // byte as signed value
  localparam int DIFF_W = VAL_W + 1;                  // value minus zero point
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ACC_W  = PROD_W + POS_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_M_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_DEPTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_N_COLS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A_IS_SIGNED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B_IS_SIGNED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_A_ZP_PER_ROW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ZP_PER_COL = 3'd6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_A_ZP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_B_ZP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COMPUTE   = 3'd4;

  // reset values of the dimension registers
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // dimension register to a usable size: zero acts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // raw byte to a signed value, per signedness flag
  function automatic logic signed [VAL_W-1:0] byte_ext(input logic [BYTE_W-1:0] raw,
                                                        input logic is_signed);
    logic signed [VAL_W-1:0] v;
    v = is_signed ? {raw[BYTE_W-1], raw} : {1'b0, raw};
    return v;
  endfunction

endpackage

FILE: rtl/core/i8mm_if.sv
// ----------------------------------------------------------------------------
// i8mm channel interfaces
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------

// command channel
interface i8mm_in_if;
  logic                             valid;
  logic                             ready;
  logic [i8mm_pkg::CMD_W-1:0]       cmd;
  logic [i8mm_pkg::INDEX_W-1:0]     index;
  logic [i8mm_pkg::BYTE_W-1:0]      value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

// result channel
interface i8mm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [i8mm_pkg::SUM_W-1:0] sum;
  logic [i8mm_pkg::POS_W-1:0]       row;
  logic [i8mm_pkg::POS_W-1:0]       col;
  logic                             last;

  modport source (output valid, output sum, output row, output col, output last, input ready);
  modport sink   (input valid, input sum, input row, input col, input last, output ready);
endinterface

FILE: rtl/core/int8_matmul_zero_point.sv
// Load beats are accepted back to back while the sequencer is idle.
// A compute beat runs, per result element, K passes through the shared
// read / multiply / accumulate sequence (S_RD, S_MUL, S_ACC), then holds the
// result in S_OUT until the beat is taken; input ready stays low until the last result goes.
// Reset (synchronous, rst_n low) clears config to defaults, zero points to zero
// and the sequencer to idle; matrix stores are not cleared.
// ----------------------------------------------------------------------------
// int8_matmul_zero_point
// Quantized 8-bit matrix multiply with single or per-row / per-column zero points,
// computed by one shared multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
module int8_matmul_zero_point (
  input  logic                                  clk,
  input  logic                                  rst_n,
  i8mm_in_if.sink                               in_ch,
  i8mm_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [i8mm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [i8mm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // configuration registers
  logic [i8mm_pkg::DIM_W-1:0] cfg_m_r, cfg_k_r, cfg_n_r;
  logic cfg_a_sgn_r, cfg_b_sgn_r, cfg_a_row_r, cfg_b_col_r;

  // stores
  logic [i8mm_pkg::BYTE_W-1:0] a_mem [i8mm_pkg::MEM_DEPTH];
  logic [i8mm_pkg::BYTE_W-1:0] b_mem [i8mm_pkg::MEM_DEPTH];
  logic [i8mm_pkg::BYTE_W-1:0] a_rd_r, b_rd_r;
  logic [i8mm_pkg::BYTE_W-1:0] zp_a_r [i8mm_pkg::MAX_DIM];
  logic [i8mm_pkg::BYTE_W-1:0] zp_b_r [i8mm_pkg::MAX_DIM];

  // sequencer state
  state_t state_r, state_nxt;
  logic [i8mm_pkg::POS_W-1:0]  i_r, i_nxt, j_r, j_nxt, kk_r, kk_nxt;
  logic [i8mm_pkg::POS_W-1:0]  m_last_r, m_last_nxt, k_last_r, k_last_nxt;
  logic [i8mm_pkg::POS_W-1:0]  n_last_r, n_last_nxt;
  logic [i8mm_pkg::DIM_W-1:0]  k_dim_r, k_dim_nxt, n_dim_r, n_dim_nxt;
  logic [i8mm_pkg::ADDR_W-1:0] a_base_r, a_base_nxt, a_addr_r, a_addr_nxt;
  logic [i8mm_pkg::ADDR_W-1:0] b_addr_r, b_addr_nxt;
  logic signed [i8mm_pkg::ACC_W-1:0]  acc_r, acc_nxt, acc_sum;
  logic signed [i8mm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [i8mm_pkg::SUM_W-1:0]  out_sum_r, out_sum_nxt;
  logic [i8mm_pkg::POS_W-1:0]  out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic                        out_last_r, out_last_nxt;

  logic in_fire, out_fire;
  logic [i8mm_pkg::DIM_W-1:0] m_cl, k_cl, n_cl;
  logic signed [i8mm_pkg::VAL_W-1:0]  a_val, b_val, zpa_val, zpb_val;
  logic signed [i8mm_pkg::DIFF_W-1:0] diff_a, diff_b;
  logic [i8mm_pkg::POS_W-1:0] zpa_sel, zpb_sel;
  logic [i8mm_pkg::ADDR_W-1:0] a_base_step;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.sum   = out_sum_r;
  assign out_ch.row   = out_row_r;
  assign out_ch.col   = out_col_r;
  assign out_ch.last  = out_last_r;
  assign out_fire     = out_ch.valid && out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_m_r     <= i8mm_pkg::DIM_RESET;
      cfg_k_r     <= i8mm_pkg::DIM_RESET;
      cfg_n_r     <= i8mm_pkg::DIM_RESET;
      cfg_a_sgn_r <= 1'b0;
      cfg_b_sgn_r <= 1'b0;
      cfg_a_row_r <= 1'b0;
      cfg_b_col_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i8mm_pkg::CFG_M_ROWS:       cfg_m_r     <= cfg_wdata;
        i8mm_pkg::CFG_K_DEPTH:      cfg_k_r     <= cfg_wdata;
        i8mm_pkg::CFG_N_COLS:       cfg_n_r     <= cfg_wdata;
        i8mm_pkg::CFG_A_IS_SIGNED:  cfg_a_sgn_r <= cfg_wdata[0];
        i8mm_pkg::CFG_B_IS_SIGNED:  cfg_b_sgn_r <= cfg_wdata[0];
        i8mm_pkg::CFG_A_ZP_PER_ROW: cfg_a_row_r <= cfg_wdata[0];
        i8mm_pkg::CFG_B_ZP_PER_COL: cfg_b_col_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // matrix A store: load writes, registered read
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.cmd == i8mm_pkg::CMD_LOAD_A) begin
      a_mem[in_ch.index] <= in_ch.value;
    end
    a_rd_r <= a_mem[a_addr_r];
  end

  // matrix B store: load writes, registered read
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.cmd == i8mm_pkg::CMD_LOAD_B) begin
      b_mem[in_ch.index] <= in_ch.value;
    end
    b_rd_r <= b_mem[b_addr_r];
  end

  // zero-point stores, cleared at reset; indexes past the store are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < i8mm_pkg::MAX_DIM; e++) begin
        zp_a_r[e] <= '0;
        zp_b_r[e] <= '0;
      end
    end else if (in_fire && in_ch.index[i8mm_pkg::INDEX_W-1:i8mm_pkg::POS_W] == '0) begin
      if (in_ch.cmd == i8mm_pkg::CMD_LOAD_A_ZP) begin
        zp_a_r[in_ch.index[i8mm_pkg::POS_W-1:0]] <= in_ch.value;
      end
      if (in_ch.cmd == i8mm_pkg::CMD_LOAD_B_ZP) begin
        zp_b_r[in_ch.index[i8mm_pkg::POS_W-1:0]] <= in_ch.value;
      end
    end
  end

  // shared multiply operands
  assign zpa_sel = cfg_a_row_r ? i_r : '0;
  assign zpb_sel = cfg_b_col_r ? j_r : '0;
  assign a_val   = i8mm_pkg::byte_ext(a_rd_r, cfg_a_sgn_r);
  assign b_val   = i8mm_pkg::byte_ext(b_rd_r, cfg_b_sgn_r);
  assign zpa_val = i8mm_pkg::byte_ext(zp_a_r[zpa_sel], cfg_a_sgn_r);
  assign zpb_val = i8mm_pkg::byte_ext(zp_b_r[zpb_sel], cfg_b_sgn_r);
  assign diff_a  = {a_val[i8mm_pkg::VAL_W-1], a_val} - {zpa_val[i8mm_pkg::VAL_W-1], zpa_val};
  assign diff_b  = {b_val[i8mm_pkg::VAL_W-1], b_val} - {zpb_val[i8mm_pkg::VAL_W-1], zpb_val};
  assign acc_sum = acc_r
                 + {{(i8mm_pkg::ACC_W-i8mm_pkg::PROD_W){prod_r[i8mm_pkg::PROD_W-1]}}, prod_r};

  // clamped dimensions for a new compute
  assign m_cl = i8mm_pkg::clamp_dim(cfg_m_r);
  assign k_cl = i8mm_pkg::clamp_dim(cfg_k_r);
  assign n_cl = i8mm_pkg::clamp_dim(cfg_n_r);
  assign a_base_step = a_base_r + {{(i8mm_pkg::ADDR_W-i8mm_pkg::DIM_W){1'b0}}, k_dim_r};

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    kk_nxt       = kk_r;
    m_last_nxt   = m_last_r;
    k_last_nxt   = k_last_r;
    n_last_nxt   = n_last_r;
    k_dim_nxt    = k_dim_r;
    n_dim_nxt    = n_dim_r;
    a_base_nxt   = a_base_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    acc_nxt      = acc_r;
    prod_nxt     = prod_r;
    out_sum_nxt  = out_sum_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        // start a compute run
        if (in_fire && in_ch.cmd == i8mm_pkg::CMD_COMPUTE) begin
          m_last_nxt = i8mm_pkg::POS_W'(m_cl - 1'b1);
          k_last_nxt = i8mm_pkg::POS_W'(k_cl - 1'b1);
          n_last_nxt = i8mm_pkg::POS_W'(n_cl - 1'b1);
          k_dim_nxt  = k_cl;
          n_dim_nxt  = n_cl;
          i_nxt      = '0;
          j_nxt      = '0;
          kk_nxt     = '0;
          a_base_nxt = '0;
          a_addr_nxt = '0;
          b_addr_nxt = '0;
          acc_nxt    = '0;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        // store reads in flight
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = diff_a * diff_b;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_sum;
        if (kk_r == k_last_r) begin
          out_sum_nxt  = i8mm_pkg::SUM_W'(acc_sum);
          out_row_nxt  = i_r;
          out_col_nxt  = j_r;
          out_last_nxt = (i_r == m_last_r) && (j_r == n_last_r);
          state_nxt    = S_OUT;
        end else begin
          kk_nxt     = kk_r + 1'b1;
          a_addr_nxt = a_addr_r + 1'b1;
          b_addr_nxt = b_addr_r + {{(i8mm_pkg::ADDR_W-i8mm_pkg::DIM_W){1'b0}}, n_dim_r};
          state_nxt  = S_RD;
        end
      end
      S_OUT: begin
        // result beat taken: move to next element or finish
        if (out_fire) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            kk_nxt    = '0;
            acc_nxt   = '0;
            state_nxt = S_RD;
            if (j_r == n_last_r) begin
              j_nxt      = '0;
              i_nxt      = i_r + 1'b1;
              a_base_nxt = a_base_step;
              a_addr_nxt = a_base_step;
              b_addr_nxt = '0;
            end else begin
              j_nxt      = j_r + 1'b1;
              a_addr_nxt = a_base_r;
              b_addr_nxt = {{(i8mm_pkg::ADDR_W-i8mm_pkg::POS_W){1'b0}}, j_r + 1'b1};
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath and index registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    kk_r       <= kk_nxt;
    m_last_r   <= m_last_nxt;
    k_last_r   <= k_last_nxt;
    n_last_r   <= n_last_nxt;
    k_dim_r    <= k_dim_nxt;
    n_dim_r    <= n_dim_nxt;
    a_base_r   <= a_base_nxt;
    a_addr_r   <= a_addr_nxt;
    b_addr_r   <= b_addr_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_sum_r  <= out_sum_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
